@@ hw/rtl/page_map_ftl_allocator_assert.svh @@
// assertion macros for the allocator checker
`ifndef PAGE_MAP_FTL_ALLOCATOR_ASSERT_SVH
`define PAGE_MAP_FTL_ALLOCATOR_ASSERT_SVH

// clocked check, masked while reset is asserted
`define PMF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds during reset
`define PMF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/pmf_pkg.sv @@
`timescale 1ns / 1ps
package pmf_pkg;
    localparam int DIES            = 8;
    localparam int CHANNELS        = 4;
    localparam int BLOCKS_PER_DIE  = 256;
    localparam int PAGES_PER_BLOCK = 64;

    localparam int LP_W   = 17;
    localparam int DIE_W  = $clog2(DIES);
    localparam int CH_W   = 2;
    localparam int WAY_W  = 1;
    localparam int BLK_W  = $clog2(BLOCKS_PER_DIE);
    localparam int OFS_W  = $clog2(PAGES_PER_BLOCK);
    localparam int SLOT_W = BLK_W + OFS_W;
    localparam int MAP_AW = DIE_W + SLOT_W;
    localparam int MAP_W  = SLOT_W + 1;
    localparam int BT_AW  = DIE_W + BLK_W;
    localparam int USED_W = $clog2(PAGES_PER_BLOCK + 1);
    localparam int BT_W   = USED_W + 2;
    localparam int CNT_W  = 12;
    localparam int BAD_THRESHOLD = 4;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_UNMAPPED = 2'd1;
    localparam logic [1:0] STAT_NOFREE   = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [DIE_W-1:0]  die;
        logic [SLOT_W-1:0] slot;
        logic [BLK_W-1:0]  mblk;
        logic              mbad;
    } cmd_t;
endpackage

@@ hw/rtl/pmf_ram.sv @@
`timescale 1ns / 1ps
module pmf_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] addr,
    input  logic [W-1:0]         wdata,
    output logic [W-1:0]         rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

@@ hw/rtl/pmf_front.sv @@
`timescale 1ns / 1ps
module pmf_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       clearing,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_action,
    input  logic [pmf_pkg::LP_W-1:0]   s_logical_page,
    input  logic [2:0]                 s_mark_die,
    input  logic [7:0]                 s_mark_block,
    input  logic [7:0]                 s_mark_byte,
    output logic                       q_valid,
    output pmf_pkg::cmd_t              q_data,
    input  logic                       q_pop
);
    pmf_pkg::cmd_t cmd_in;
    pmf_pkg::cmd_t q_reg [2];
    logic          wr_reg, wr_next, rd_reg, rd_next;
    logic [1:0]    cnt_reg, cnt_next;
    logic [3:0]    ones;
    logic          push;

    // classify: die / slot split and bad-mark decision
    always_comb begin
        ones = '0;
        for (int i = 0; i < 8; i++) begin
            ones = ones + {3'd0, s_mark_byte[i]};
        end
        cmd_in        = '0;
        cmd_in.action = s_action;
        if (s_action == pmf_pkg::ACT_LOAD) begin
            cmd_in.die  = s_mark_die[pmf_pkg::DIE_W-1:0];
            cmd_in.mblk = s_mark_block[pmf_pkg::BLK_W-1:0];
            cmd_in.mbad = (ones < 4'(pmf_pkg::BAD_THRESHOLD));
        end else if (s_action == pmf_pkg::ACT_WRITE || s_action == pmf_pkg::ACT_READ) begin
            cmd_in.die  = s_logical_page[pmf_pkg::DIE_W-1:0];
            cmd_in.slot = s_logical_page[pmf_pkg::DIE_W +: pmf_pkg::SLOT_W];
        end
    end

    assign s_ready = !clearing && (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_data  = q_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg ^ push;
        rd_next  = rd_reg ^ q_pop;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_reg] <= cmd_in;
        end
        if (!aresetn) begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule

@@ hw/rtl/pmf_back.sv @@
`timescale 1ns / 1ps
module pmf_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    output logic                        clearing,
    input  logic                        q_valid,
    input  pmf_pkg::cmd_t               q_data,
    output logic                        q_pop,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [2:0]                  m_die_index,
    output logic [1:0]                  m_channel_index,
    output logic [0:0]                  m_way_index,
    output logic [13:0]                 m_physical_page,
    output logic [13:0]                 m_previous_page,
    output logic [0:0]                  m_previous_mapped,
    output logic [11:0]                 m_bad_block_count
);
    localparam int DIE_W  = pmf_pkg::DIE_W;
    localparam int BLK_W  = pmf_pkg::BLK_W;
    localparam int OFS_W  = pmf_pkg::OFS_W;
    localparam int SLOT_W = pmf_pkg::SLOT_W;
    localparam int USED_W = pmf_pkg::USED_W;
    localparam int MAP_AW = pmf_pkg::MAP_AW;
    localparam int CNT_W  = pmf_pkg::CNT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_SRD  = 2'd2;
    localparam logic [1:0] S_SCHK = 2'd3;

    logic [1:0]  state_reg, state_next;
    pmf_pkg::cmd_t cmd_reg, cmd_next, cmd_sel;
    logic [BLK_W:0] k_reg, k_next;
    logic [BLK_W-1:0] open_reg [pmf_pkg::DIES];
    logic [BLK_W-1:0] open_next [pmf_pkg::DIES];
    logic [pmf_pkg::CNT_W-1:0] bad_reg, bad_next;
    logic clr_reg;
    logic [pmf_pkg::MAP_AW-1:0] clr_cnt_reg;

    logic [pmf_pkg::MAP_AW-1:0] map_addr;
    logic [pmf_pkg::MAP_W-1:0]  map_wdata, map_rd;
    logic                       map_we;
    logic [pmf_pkg::BT_AW-1:0]  bt_addr;
    logic [pmf_pkg::BT_W-1:0]   bt_wdata, bt_rd;
    logic                       bt_we;

    logic [BLK_W-1:0]  cur, blk_b, clr_blk;
    logic [DIE_W-1:0]  clr_die;
    logic [USED_W-1:0] used;
    logic              e_bad, e_free, out_free, finish;
    logic [1:0]        r_status;
    logic [DIE_W-1:0]  r_die;
    logic [SLOT_W-1:0] r_page, r_prev;
    logic              r_pmap;

    logic              mv_reg;
    logic [1:0]        st_reg;
    logic [DIE_W-1:0]  die_reg;
    logic [SLOT_W-1:0] pg_reg, prev_reg;
    logic              pmap_reg;

    assign clearing = clr_reg;
    assign used     = bt_rd[USED_W-1:0];
    assign e_bad    = bt_rd[USED_W];
    assign e_free   = bt_rd[USED_W+1];
    assign out_free = !mv_reg || m_ready;
    assign q_pop    = (state_reg == S_IDLE) && q_valid && !clr_reg;

    assign clr_blk = clr_cnt_reg[BLK_W-1:0];
    assign clr_die = clr_cnt_reg[BLK_W +: DIE_W];

    always_comb begin
        cmd_sel = (state_reg == S_IDLE) ? q_data : cmd_reg;
        cur     = open_reg[cmd_sel.die];
        if (state_reg == S_SRD || state_reg == S_SCHK) begin
            blk_b = cur + k_reg[BLK_W-1:0];
        end else if (cmd_sel.action == pmf_pkg::ACT_LOAD) begin
            blk_b = cmd_sel.mblk;
        end else begin
            blk_b = cur;
        end
        map_addr = clr_reg ? clr_cnt_reg : {cmd_sel.die, cmd_sel.slot};
        bt_addr  = clr_reg ? clr_cnt_reg[pmf_pkg::BT_AW-1:0] : {cmd_sel.die, blk_b};
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        k_next     = k_reg;
        open_next  = open_reg;
        bad_next   = bad_reg;
        map_we     = 1'b0;
        map_wdata  = '0;
        bt_we      = 1'b0;
        bt_wdata   = '0;
        finish     = 1'b0;
        r_status   = pmf_pkg::STAT_OK;
        r_die      = cmd_reg.die;
        r_page     = '0;
        r_prev     = '0;
        r_pmap     = 1'b0;
        if (clr_reg) begin
            // reset sweep: map unmapped, reserved blocks taken
            map_we = 1'b1;
            bt_we  = (clr_cnt_reg[pmf_pkg::MAP_AW-1:pmf_pkg::BT_AW] == '0);
            bt_wdata = {!((clr_blk == '0) || (clr_die == '0 && clr_blk == BLK_W'(1))),
                        1'b0, {USED_W{1'b0}}};
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (q_pop) begin
                        cmd_next   = q_data;
                        state_next = S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        case (cmd_reg.action)
                            pmf_pkg::ACT_WRITE: begin
                                if (used >= USED_W'(pmf_pkg::PAGES_PER_BLOCK)) begin
                                    k_next     = (BLK_W+1)'(1);
                                    state_next = S_SRD;
                                end else begin
                                    finish    = 1'b1;
                                    r_page    = {cur, used[OFS_W-1:0]};
                                    bt_we     = 1'b1;
                                    bt_wdata  = {e_free, e_bad, used + USED_W'(1)};
                                end
                            end
                            pmf_pkg::ACT_READ: begin
                                finish = 1'b1;
                                if (map_rd[SLOT_W]) begin
                                    r_page = map_rd[SLOT_W-1:0];
                                end else begin
                                    r_status = pmf_pkg::STAT_UNMAPPED;
                                end
                            end
                            pmf_pkg::ACT_LOAD: begin
                                finish   = 1'b1;
                                bt_we    = 1'b1;
                                bt_wdata = {e_free, cmd_reg.mbad, used};
                                if (cmd_reg.mbad && !e_bad) begin
                                    bad_next = bad_reg + CNT_W'(1);
                                end else if (!cmd_reg.mbad && e_bad) begin
                                    bad_next = bad_reg - CNT_W'(1);
                                end
                            end
                            default: begin
                                finish = 1'b1;
                                r_die  = '0;
                            end
                        endcase
                    end
                end
                S_SRD: begin
                    state_next = S_SCHK;
                end
                S_SCHK: begin
                    if (e_free && !e_bad) begin
                        if (out_free) begin
                            finish   = 1'b1;
                            r_page   = {blk_b, {OFS_W{1'b0}}};
                            bt_we    = 1'b1;
                            bt_wdata = {1'b0, e_bad, USED_W'(1)};
                            open_next[cmd_reg.die] = blk_b;
                        end
                    end else if (k_reg == (BLK_W+1)'(pmf_pkg::BLOCKS_PER_DIE)) begin
                        if (out_free) begin
                            finish   = 1'b1;
                            r_status = pmf_pkg::STAT_NOFREE;
                        end
                    end else begin
                        k_next     = k_reg + (BLK_W+1)'(1);
                        state_next = S_SRD;
                    end
                end
                default: state_next = S_IDLE;
            endcase
            if (finish) begin
                state_next = S_IDLE;
                // a successful write replaces the mapping
                if (cmd_reg.action == pmf_pkg::ACT_WRITE && r_status == pmf_pkg::STAT_OK) begin
                    map_we    = 1'b1;
                    map_wdata = {1'b1, r_page};
                    r_pmap    = map_rd[SLOT_W];
                    r_prev    = map_rd[SLOT_W] ? map_rd[SLOT_W-1:0] : '0;
                end
            end
        end
    end

    pmf_ram #(.W(pmf_pkg::MAP_W), .D(pmf_pkg::DIES * pmf_pkg::BLOCKS_PER_DIE *
              pmf_pkg::PAGES_PER_BLOCK)) u_map (
        .aclk(aclk), .we(map_we), .addr(map_addr), .wdata(map_wdata), .rdata(map_rd)
    );

    pmf_ram #(.W(pmf_pkg::BT_W), .D(pmf_pkg::DIES * pmf_pkg::BLOCKS_PER_DIE)) u_blk (
        .aclk(aclk), .we(bt_we), .addr(bt_addr), .wdata(bt_wdata), .rdata(bt_rd)
    );

    always_ff @(posedge aclk) begin
        if (finish) begin
            st_reg   <= r_status;
            die_reg  <= r_die;
            pg_reg   <= r_page;
            prev_reg <= r_prev;
            pmap_reg <= r_pmap;
        end
        cmd_reg <= cmd_next;
        k_reg   <= k_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
            bad_reg     <= '0;
            mv_reg      <= 1'b0;
            for (int d = 0; d < pmf_pkg::DIES; d++) begin
                open_reg[d] <= (d == 0) ? BLK_W'(1) : '0;
            end
        end else begin
            state_reg <= state_next;
            bad_reg   <= bad_next;
            open_reg  <= open_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + MAP_AW'(1);
                if (clr_cnt_reg == '1) begin
                    clr_reg <= 1'b0;
                end
            end
            if (finish) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    assign m_valid           = mv_reg;
    assign m_status          = st_reg;
    assign m_die_index       = die_reg;
    assign m_channel_index   = die_reg[pmf_pkg::CH_W-1:0];
    assign m_way_index       = die_reg[DIE_W-1 -: pmf_pkg::WAY_W];
    assign m_physical_page   = pg_reg;
    assign m_previous_page   = prev_reg;
    assign m_previous_mapped = pmap_reg;
    assign m_bad_block_count = bad_reg;
endmodule

@@ hw/rtl/page_map_ftl_allocator.sv @@
`timescale 1ns / 1ps
// page-mapped flash allocator: one logical page operation per input beat
// s_ channel: action, logical_page and the bad-mark fields (valid/ready)
// m_ channel: status, die/channel/way, physical and previous page, bad count
// every accepted beat gives exactly one result beat, in order
// a write into a full block walks the die's block table, examining up to
//   256 blocks, before answering
// the single back-end sequencer finishes one command before it takes the next,
//   as it waits on its registered map / block-table reads
// a 2-entry command queue sits between the front classifier and the back end,
//   so new beats are taken while a result waits in the output register
// when m_ready is low the result holds, the back end stalls at its last step
//   and the queue fills, then s_ready drops
// reset: a clearing pass writes every map entry unmapped and
//   reloads the block table (block 0 of each die and block 1 of die 0 taken);
//   s_ready stays low until it ends
module page_map_ftl_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [16:0] s_logical_page,
    input  logic [2:0]  s_mark_die,
    input  logic [7:0]  s_mark_block,
    input  logic [7:0]  s_mark_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_die_index,
    output logic [1:0]  m_channel_index,
    output logic [0:0]  m_way_index,
    output logic [13:0] m_physical_page,
    output logic [13:0] m_previous_page,
    output logic [0:0]  m_previous_mapped,
    output logic [11:0] m_bad_block_count
);
    logic          clearing;
    logic          q_valid, q_pop;
    pmf_pkg::cmd_t q_data;

    // front: classify beats into commands and queue them
    pmf_front u_front (
        .aclk(aclk), .aresetn(aresetn), .clearing(clearing),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_logical_page(s_logical_page), .s_mark_die(s_mark_die),
        .s_mark_block(s_mark_block), .s_mark_byte(s_mark_byte),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
    );

    // back: map / block-table sequencer with the result register
    pmf_back u_back (
        .aclk(aclk), .aresetn(aresetn), .clearing(clearing),
        .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_die_index(m_die_index), .m_channel_index(m_channel_index),
        .m_way_index(m_way_index), .m_physical_page(m_physical_page),
        .m_previous_page(m_previous_page), .m_previous_mapped(m_previous_mapped),
        .m_bad_block_count(m_bad_block_count)
    );
endmodule

@@ hw/rtl/pmf_checker.sv @@
`timescale 1ns / 1ps
`include "page_map_ftl_allocator_assert.svh"
module pmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_status,
    input logic [2:0]  m_die_index,
    input logic [1:0]  m_channel_index,
    input logic [0:0]  m_way_index,
    input logic [13:0] m_physical_page,
    input logic [13:0] m_previous_page,
    input logic [0:0]  m_previous_mapped
);
    logic stalled, code_ok, route_ok, fail_beat, zero_ok;

    assign stalled   = m_valid && !m_ready;
    assign code_ok   = (m_status == pmf_pkg::STAT_OK) ||
                       (m_status == pmf_pkg::STAT_UNMAPPED) ||
                       (m_status == pmf_pkg::STAT_NOFREE);
    assign route_ok  = (m_channel_index == m_die_index[pmf_pkg::CH_W-1:0]) &&
                       (m_way_index == m_die_index[pmf_pkg::DIE_W-1]);
    assign fail_beat = m_valid && (m_status != pmf_pkg::STAT_OK);
    assign zero_ok   = (m_physical_page == '0) && (m_previous_page == '0) &&
                       (m_previous_mapped == '0);

    `PMF_ASSERT(a_hold, stalled |=> m_valid && $stable(m_physical_page), "result dropped")
    `PMF_ASSERT(a_code, m_valid |-> code_ok, "undefined status code")
    `PMF_ASSERT(a_route, m_valid |-> route_ok, "channel or way does not follow die")
    `PMF_ASSERT(a_err_zero, fail_beat |-> zero_ok, "page fields set on failure")
    `PMF_ASSERT_ALWAYS(a_rst, !aresetn |=> !m_valid && !s_ready, "handshake active after reset")
endmodule

bind page_map_ftl_allocator pmf_checker u_pmf_checker (.*);
